### rtl/i2cm_pkg.sv
// Package for the I2C master byte controller.
// Holds the command codes, the bus sequencing constants and the word types.
// No dependencies.
package i2cm_pkg;

    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    localparam logic [3:0] LAST_GROUP  = 4'd8;
    localparam logic [15:0] DELAY_RESET = 16'd60;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } cmd_word_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic       ack_received;
        logic [7:0] rx_byte;
    } res_word_t;

endpackage

### rtl/i2cm_chan_if.sv
// Valid/ready channel that carries one word per handshake.
// The word type is a parameter; the controller uses the types of i2cm_pkg.
interface i2cm_chan_if #(
    parameter type word_t = logic
);
    logic  valid;
    logic  ready;
    word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/i2c_master_byte_controller.sv
// I2C master byte controller: top level and only module.
// Depends on i2cm_pkg (codes and word types) and i2cm_chan_if (channels).
//
// Usage: every word on the cmd channel is one tick of the bus sequencer. It
// carries a command (none, start, stop, write byte, read byte), the byte to
// send, the ACK to drive after a read, and the sampled SDA level. A command is
// taken only while the controller is idle; while busy the op field is ignored,
// but the tick still advances the sequence. Each bus phase lasts delay_ticks
// ticks (0 acts as 1), written through cfg_we/cfg_wdata only while idle; the
// user must keep to this and the block does not enforce it. For every accepted
// cmd word exactly one word appears on the res channel, giving the SCL and SDA
// levels, busy, a done pulse on the last tick of a command, the last ACK seen
// by a write and the last byte read. A result word appears in the cycle after
// acceptance; throughput is one word per cycle while the receiver does not
// stall, set by the single update of state and result registers. On a stall
// the result register holds its word and cmd.ready drops, so no tick is lost.
// Reset leaves the bus released (SCL and SDA high), the controller idle, the
// result register empty and delay_ticks at 60.
module i2c_master_byte_controller (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata,
    i2cm_chan_if.sink    cmd,
    i2cm_chan_if.source  res
);

    logic [15:0] delay_reg;
    logic [2:0]  cur_cmd_reg,    cur_cmd_next;
    logic [1:0]  phase_step_reg, phase_step_next;
    logic [15:0] phase_timer_reg, phase_timer_next;
    logic [3:0]  bit_index_reg,  bit_index_next;
    logic [7:0]  shift_data_reg, shift_data_next;
    logic        ack_flag_reg,   ack_flag_next;
    logic        scl_level_reg,  scl_level_next;
    logic        sda_level_reg,  sda_level_next;
    logic        ack_to_send_reg, ack_to_send_next;
    logic [7:0]  rx_hold_reg,    rx_hold_next;
    logic        res_valid_reg;
    i2cm_pkg::res_word_t res_word_reg, res_word_next;

    i2cm_pkg::cmd_word_t cw;
    logic        accept;
    logic        start_new;
    logic [15:0] eff_delay;
    logic [16:0] timer_inc;
    logic [1:0]  step_inc;
    logic [1:0]  group_len;
    logic [3:0]  final_group;
    logic        done;

    assign cw        = cmd.payload;
    assign cmd.ready = !res_valid_reg || res.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign eff_delay = (delay_reg == 16'd0) ? 16'd1 : delay_reg;
    assign res.valid   = res_valid_reg;
    assign res.payload = res_word_reg;

    always_comb
    begin
        cur_cmd_next     = cur_cmd_reg;
        phase_step_next  = phase_step_reg;
        phase_timer_next = phase_timer_reg;
        bit_index_next   = bit_index_reg;
        shift_data_next  = shift_data_reg;
        ack_flag_next    = ack_flag_reg;
        scl_level_next   = scl_level_reg;
        sda_level_next   = sda_level_reg;
        ack_to_send_next = ack_to_send_reg;
        rx_hold_next     = rx_hold_reg;
        done             = 1'b0;
        timer_inc        = 17'd0;
        step_inc         = 2'd0;
        group_len        = 2'd3;
        final_group      = 4'd0;

        start_new = (cur_cmd_reg == i2cm_pkg::CMD_NONE)
                    && (cw.op inside {[i2cm_pkg::CMD_START:i2cm_pkg::CMD_READ]});

        if (start_new)
        begin
            cur_cmd_next     = cw.op;
            phase_step_next  = 2'd0;
            phase_timer_next = 16'd0;
            bit_index_next   = 4'd0;
            if (cw.op == i2cm_pkg::CMD_WRITE)
            begin
                shift_data_next = cw.tx_byte;
            end
            if (cw.op == i2cm_pkg::CMD_READ)
            begin
                shift_data_next  = 8'd0;
                ack_to_send_next = cw.send_ack;
            end
        end

        if (cur_cmd_next != i2cm_pkg::CMD_NONE)
        begin
            // Line levels are set on the first tick of each phase.
            if (phase_timer_next == 16'd0)
            begin
                case (cur_cmd_next)
                    i2cm_pkg::CMD_START:
                    begin
                        if (phase_step_next == 2'd0)
                        begin
                            sda_level_next = 1'b1;
                            scl_level_next = 1'b1;
                        end
                        else if (phase_step_next == 2'd1)
                        begin
                            sda_level_next = 1'b0;
                        end
                        else
                        begin
                            scl_level_next = 1'b0;
                        end
                    end
                    i2cm_pkg::CMD_STOP:
                    begin
                        if (phase_step_next == 2'd0)
                        begin
                            sda_level_next = 1'b0;
                        end
                        else if (phase_step_next == 2'd1)
                        begin
                            scl_level_next = 1'b1;
                        end
                        else
                        begin
                            sda_level_next = 1'b1;
                        end
                    end
                    i2cm_pkg::CMD_WRITE:
                    begin
                        if (phase_step_next == 2'd0)
                        begin
                            sda_level_next = (bit_index_next < i2cm_pkg::LAST_GROUP)
                                             ? shift_data_next[7] : 1'b1;
                        end
                        else if (phase_step_next == 2'd1)
                        begin
                            scl_level_next = 1'b1;
                        end
                        else
                        begin
                            scl_level_next = 1'b0;
                        end
                    end
                    default:
                    begin
                        if (bit_index_next < i2cm_pkg::LAST_GROUP)
                        begin
                            if (bit_index_next == 4'd0 && phase_step_next == 2'd0)
                            begin
                                sda_level_next = 1'b1;
                            end
                            scl_level_next = (phase_step_next == 2'd0);
                        end
                        else if (phase_step_next == 2'd0)
                        begin
                            sda_level_next = !ack_to_send_next;
                        end
                        else if (phase_step_next == 2'd1)
                        begin
                            scl_level_next = 1'b1;
                        end
                        else
                        begin
                            scl_level_next = 1'b0;
                        end
                    end
                endcase
            end

            timer_inc = {1'b0, phase_timer_next} + 17'd1;
            if (timer_inc >= {1'b0, eff_delay})
            begin
                phase_timer_next = 16'd0;
                if (cur_cmd_next == i2cm_pkg::CMD_WRITE)
                begin
                    if (bit_index_next < i2cm_pkg::LAST_GROUP && phase_step_next == 2'd2)
                    begin
                        shift_data_next = {shift_data_next[6:0], 1'b0};
                    end
                    if (bit_index_next == i2cm_pkg::LAST_GROUP && phase_step_next == 2'd1)
                    begin
                        ack_flag_next = !cw.sda_in;
                    end
                end
                else if (cur_cmd_next == i2cm_pkg::CMD_READ)
                begin
                    if (bit_index_next < i2cm_pkg::LAST_GROUP && phase_step_next == 2'd0)
                    begin
                        shift_data_next = {shift_data_next[6:0], cw.sda_in};
                    end
                end

                if (cur_cmd_next == i2cm_pkg::CMD_READ
                    && bit_index_next < i2cm_pkg::LAST_GROUP)
                begin
                    group_len = 2'd2;
                end
                if (cur_cmd_next == i2cm_pkg::CMD_WRITE || cur_cmd_next == i2cm_pkg::CMD_READ)
                begin
                    final_group = i2cm_pkg::LAST_GROUP;
                end

                step_inc = phase_step_next + 2'd1;
                if (step_inc >= group_len)
                begin
                    phase_step_next = 2'd0;
                    if (bit_index_next >= final_group)
                    begin
                        if (cur_cmd_next == i2cm_pkg::CMD_READ)
                        begin
                            sda_level_next = 1'b1;
                            rx_hold_next   = shift_data_next;
                        end
                        cur_cmd_next   = i2cm_pkg::CMD_NONE;
                        bit_index_next = 4'd0;
                        done           = 1'b1;
                    end
                    else
                    begin
                        bit_index_next = bit_index_next + 4'd1;
                    end
                end
                else
                begin
                    phase_step_next = step_inc;
                end
            end
            else
            begin
                phase_timer_next = timer_inc[15:0];
            end
        end

        res_word_next.scl_out      = scl_level_next;
        res_word_next.sda_out      = sda_level_next;
        res_word_next.busy_res     = (cur_cmd_next != i2cm_pkg::CMD_NONE);
        res_word_next.done_res     = done;
        res_word_next.ack_received = ack_flag_next;
        res_word_next.rx_byte      = rx_hold_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg       <= i2cm_pkg::DELAY_RESET;
            cur_cmd_reg     <= i2cm_pkg::CMD_NONE;
            phase_step_reg  <= 2'd0;
            phase_timer_reg <= 16'd0;
            bit_index_reg   <= 4'd0;
            shift_data_reg  <= 8'd0;
            ack_flag_reg    <= 1'b0;
            scl_level_reg   <= 1'b1;
            sda_level_reg   <= 1'b1;
            ack_to_send_reg <= 1'b0;
            rx_hold_reg     <= 8'd0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                delay_reg <= cfg_wdata;
            end
            if (accept)
            begin
                cur_cmd_reg     <= cur_cmd_next;
                phase_step_reg  <= phase_step_next;
                phase_timer_reg <= phase_timer_next;
                bit_index_reg   <= bit_index_next;
                shift_data_reg  <= shift_data_next;
                ack_flag_reg    <= ack_flag_next;
                scl_level_reg   <= scl_level_next;
                sda_level_reg   <= sda_level_next;
                ack_to_send_reg <= ack_to_send_next;
                rx_hold_reg     <= rx_hold_next;
                res_valid_reg   <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_word_reg <= res_word_next;
        end
    end

endmodule

### verif/i2c_master_byte_controller_tb.sv
// Self-checking testbench for the I2C master byte controller: a directed command table,
// then random start/write/read/stop transactions, with every result word checked.
// Depends on i2cm_pkg, i2cm_chan_if and i2c_master_byte_controller.
module i2c_master_byte_controller_tb;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int IDLE_PCT = 34;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int PHASE_TICKS = 40;
    localparam int REPORT_MAX = 10;
    localparam int SHORTEN_TICKS = 80;
    localparam logic [15:0] SHORT_DELAY = 16'd3;
    localparam logic [1:0] SDA_RANDOM = 2'd2;

    typedef struct packed {
        logic [15:0] delay;
        logic [2:0]  op;
        logic [7:0]  tx;
        logic        sack;
        logic        sda;
        logic        chk;
        logic        ack;
        logic [7:0]  rx;
    } plan_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    i2cm_chan_if #(.word_t(i2cm_pkg::cmd_word_t)) cmd_ch ();
    i2cm_chan_if #(.word_t(i2cm_pkg::res_word_t)) res_ch ();

    i2c_master_byte_controller u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_ch),
        .res       (res_ch)
    );

    // Mirror of the bus sequencer state.
    logic [2:0]  bus_cmd;
    logic [1:0]  bus_step;
    logic [15:0] bus_timer;
    logic [3:0]  bit_group;
    logic [7:0]  shift_reg;
    logic        ack_seen;
    logic        scl_lvl;
    logic        sda_lvl;
    logic        ack_drive;
    logic [7:0]  rx_last;
    logic [15:0] delay_reg;

    i2cm_pkg::res_word_t bus_word_q [$];
    i2cm_pkg::res_word_t want;
    plan_row_t   plan [0:16];
    logic [15:0] random_delays [5] = '{16'd1, 16'd0, 16'd2, 16'd1, 16'd0};
    int          mismatches = 0;
    int          cycles = 0;
    int          ticks_sent = 0;
    int          hold_off_asked = 0;
    int          hold_off_served = 0;
    int          hold_left = 0;
    bit          calm = 1'b0;

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic i2cm_pkg::res_word_t advance_bus_tick(input i2cm_pkg::cmd_word_t w);
        logic [15:0] eff;
        logic        fin;
        logic [1:0]  glen;
        logic [3:0]  last_group;
        i2cm_pkg::res_word_t r;
        eff = (delay_reg == 16'd0) ? 16'd1 : delay_reg;
        fin = 1'b0;
        if (bus_cmd == i2cm_pkg::CMD_NONE && w.op >= i2cm_pkg::CMD_START
            && w.op <= i2cm_pkg::CMD_READ)
        begin
            bus_cmd = w.op;
            bus_step = 2'd0;
            bus_timer = 16'd0;
            bit_group = 4'd0;
            if (w.op == i2cm_pkg::CMD_WRITE)
                shift_reg = w.tx_byte;
            if (w.op == i2cm_pkg::CMD_READ)
            begin
                shift_reg = 8'd0;
                ack_drive = w.send_ack;
            end
        end
        if (bus_cmd != i2cm_pkg::CMD_NONE)
        begin
            if (bus_timer == 16'd0)
            begin
                case (bus_cmd)
                    i2cm_pkg::CMD_START:
                    begin
                        if (bus_step == 2'd0)
                        begin
                            sda_lvl = 1'b1;
                            scl_lvl = 1'b1;
                        end
                        else if (bus_step == 2'd1)
                            sda_lvl = 1'b0;
                        else
                            scl_lvl = 1'b0;
                    end
                    i2cm_pkg::CMD_STOP:
                    begin
                        if (bus_step == 2'd0)
                            sda_lvl = 1'b0;
                        else if (bus_step == 2'd1)
                            scl_lvl = 1'b1;
                        else
                            sda_lvl = 1'b1;
                    end
                    i2cm_pkg::CMD_WRITE:
                    begin
                        if (bus_step == 2'd0)
                            sda_lvl = (bit_group < i2cm_pkg::LAST_GROUP) ? shift_reg[7] : 1'b1;
                        else if (bus_step == 2'd1)
                            scl_lvl = 1'b1;
                        else
                            scl_lvl = 1'b0;
                    end
                    default:
                    begin
                        if (bit_group < i2cm_pkg::LAST_GROUP)
                        begin
                            if (bit_group == 4'd0 && bus_step == 2'd0)
                                sda_lvl = 1'b1;
                            scl_lvl = (bus_step == 2'd0);
                        end
                        else if (bus_step == 2'd0)
                            sda_lvl = ~ack_drive;
                        else if (bus_step == 2'd1)
                            scl_lvl = 1'b1;
                        else
                            scl_lvl = 1'b0;
                    end
                endcase
            end
            if (({1'b0, bus_timer} + 17'd1) >= {1'b0, eff})
            begin
                bus_timer = 16'd0;
                if (bus_cmd == i2cm_pkg::CMD_WRITE)
                begin
                    if (bit_group < i2cm_pkg::LAST_GROUP && bus_step == 2'd2)
                        shift_reg = {shift_reg[6:0], 1'b0};
                    if (bit_group == i2cm_pkg::LAST_GROUP && bus_step == 2'd1)
                        ack_seen = ~w.sda_in;
                end
                else if (bus_cmd == i2cm_pkg::CMD_READ && bit_group < i2cm_pkg::LAST_GROUP
                         && bus_step == 2'd0)
                    shift_reg = {shift_reg[6:0], w.sda_in};
                bus_step = bus_step + 2'd1;
                glen = (bus_cmd == i2cm_pkg::CMD_READ && bit_group < i2cm_pkg::LAST_GROUP)
                       ? 2'd2 : 2'd3;
                last_group = (bus_cmd == i2cm_pkg::CMD_WRITE || bus_cmd == i2cm_pkg::CMD_READ)
                             ? i2cm_pkg::LAST_GROUP : 4'd0;
                if (bus_step >= glen)
                begin
                    bus_step = 2'd0;
                    if (bit_group >= last_group)
                    begin
                        if (bus_cmd == i2cm_pkg::CMD_READ)
                        begin
                            sda_lvl = 1'b1;
                            rx_last = shift_reg;
                        end
                        fin = 1'b1;
                    end
                    else
                        bit_group = bit_group + 4'd1;
                end
                if (fin)
                begin
                    bus_cmd = i2cm_pkg::CMD_NONE;
                    bit_group = 4'd0;
                end
            end
            else
                bus_timer = bus_timer + 16'd1;
        end
        r.scl_out = scl_lvl;
        r.sda_out = sda_lvl;
        r.busy_res = (bus_cmd != i2cm_pkg::CMD_NONE);
        r.done_res = fin;
        r.ack_received = ack_seen;
        r.rx_byte = rx_last;
        return r;
    endfunction

    // Offers one tick word, after random gaps unless calm, and records its expected result.
    task automatic send_tick(input i2cm_pkg::cmd_word_t w);
        @(negedge clk);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.payload <= w;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        bus_word_q.push_back(advance_bus_tick(w));
        ticks_sent++;
    endtask

    // Issues one command and keeps ticking until the controller is idle again.
    task automatic run_command(input logic [2:0] op, input logic [7:0] tx, input logic sack,
                               input logic [1:0] sda_mode);
        i2cm_pkg::cmd_word_t w;
        w.op = op;
        w.tx_byte = tx;
        w.send_ack = sack;
        w.sda_in = (sda_mode == SDA_RANDOM) ? 1'($urandom_range(1)) : sda_mode[0];
        send_tick(w);
        while (bus_cmd != i2cm_pkg::CMD_NONE)
        begin
            w.op = 3'($urandom_range(7));
            w.tx_byte = 8'($urandom_range(255));
            w.send_ack = 1'($urandom_range(1));
            if (sda_mode == SDA_RANDOM)
                w.sda_in = 1'($urandom_range(1));
            send_tick(w);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (bus_word_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_delay(input logic [15:0] value);
        drain();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        delay_reg = value;
    endtask

    // Starts a command at the current long delay, then shortens the delay during the first
    // phase and runs the command to its end.
    task automatic run_shortened(input logic [2:0] op, input logic [7:0] tx, input logic sack,
                                 input logic sda);
        i2cm_pkg::cmd_word_t w;
        w.op = op;
        w.tx_byte = tx;
        w.send_ack = sack;
        w.sda_in = sda;
        repeat (SHORTEN_TICKS)
            send_tick(w);
        set_delay(SHORT_DELAY);
        while (bus_cmd != i2cm_pkg::CMD_NONE)
            send_tick(w);
    endtask

    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            res_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_off_served != hold_off_asked)
        begin
            res_ch.ready <= 1'b0;
            hold_left <= HOLD_OFF_CYCLES;
            hold_off_served <= hold_off_asked;
        end
        else
            res_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (bus_word_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("cycle %0d: result word with none expected: %h", cycles,
                             res_ch.payload);
            end
            else
            begin
                want = bus_word_q.pop_front();
                if (res_ch.payload.scl_out !== want.scl_out
                    || res_ch.payload.sda_out !== want.sda_out
                    || res_ch.payload.busy_res !== want.busy_res
                    || res_ch.payload.done_res !== want.done_res
                    || res_ch.payload.ack_received !== want.ack_received
                    || res_ch.payload.rx_byte !== want.rx_byte)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("cycle %0d: expected scl %b sda %b busy %b done %b ack %b rx %h,%s",
                                 cycles, want.scl_out, want.sda_out, want.busy_res,
                                 want.done_res, want.ack_received, want.rx_byte,
                                 $sformatf(" got scl %b sda %b busy %b done %b ack %b rx %h",
                                           res_ch.payload.scl_out, res_ch.payload.sda_out,
                                           res_ch.payload.busy_res, res_ch.payload.done_res,
                                           res_ch.payload.ack_received,
                                           res_ch.payload.rx_byte));
                end
            end
        end
    end

    initial
    begin
        int        p;
        int        phase_start;
        int        pick;
        bit        first;
        i2cm_pkg::res_word_t last_word;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 16'd0;
        cmd_ch.valid = 1'b0;
        cmd_ch.payload = '0;
        res_ch.ready = 1'b0;
        bus_cmd = i2cm_pkg::CMD_NONE;
        bus_step = 2'd0;
        bus_timer = 16'd0;
        bit_group = 4'd0;
        shift_reg = 8'd0;
        ack_seen = 1'b0;
        scl_lvl = 1'b1;
        sda_lvl = 1'b1;
        ack_drive = 1'b0;
        rx_last = 8'd0;
        delay_reg = i2cm_pkg::DELAY_RESET;

        // Columns: delay, op, tx byte, send ack, sda in, typed check, ack, rx byte.
        plan = '{
            '{16'd60,   i2cm_pkg::CMD_NONE,  8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00},
            '{16'd60,   i2cm_pkg::CMD_START, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00},
            '{16'd1,    i2cm_pkg::CMD_WRITE, 8'hFF, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00},
            '{16'd1,    i2cm_pkg::CMD_WRITE, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00},
            '{16'd1,    i2cm_pkg::CMD_READ,  8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 8'hFF},
            '{16'd1,    i2cm_pkg::CMD_READ,  8'hFF, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00},
            '{16'd1,    i2cm_pkg::CMD_WRITE, 8'h80, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00},
            '{16'd0,    i2cm_pkg::CMD_WRITE, 8'hA5, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00},
            '{16'd0,    i2cm_pkg::CMD_READ,  8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF},
            '{16'd0,    3'(i2cm_pkg::CMD_READ + 1), 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
            '{16'd0,    3'(i2cm_pkg::CMD_READ + 2), 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00},
            '{16'd0,    3'(i2cm_pkg::CMD_READ + 3), 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
            '{16'd2,    i2cm_pkg::CMD_STOP,  8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00},
            '{16'd2,    i2cm_pkg::CMD_WRITE, 8'h5A, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00},
            '{16'hFFFF, i2cm_pkg::CMD_START, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00},
            '{16'd3,    i2cm_pkg::CMD_STOP,  8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00},
            '{16'd1,    i2cm_pkg::CMD_READ,  8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00}
        };

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].delay != delay_reg)
                set_delay(plan[i].delay);
            // Both sides stay willing for the whole longest-delay row.
            calm = (plan[i].delay == 16'hFFFF);
            if (calm)
                run_shortened(plan[i].op, plan[i].tx, plan[i].sack, plan[i].sda);
            else
                run_command(plan[i].op, plan[i].tx, plan[i].sack, {1'b0, plan[i].sda});
            if (plan[i].chk)
            begin
                last_word = bus_word_q[bus_word_q.size() - 1];
                last_word.ack_received = plan[i].ack;
                last_word.rx_byte = plan[i].rx;
                bus_word_q[bus_word_q.size() - 1] = last_word;
            end
        end
        calm = 1'b0;

        for (p = 0; p < 5; p++)
        begin
            set_delay(random_delays[p]);
            phase_start = ticks_sent;
            first = 1'b1;
            while (ticks_sent - phase_start < PHASE_TICKS)
            begin
                // In the first random phase the receiver stalls while the sender offers.
                if (first && p == 0)
                    hold_off_asked++;
                if ($urandom_range(99) < 80)
                begin
                    run_command(i2cm_pkg::CMD_START, 8'($urandom_range(255)),
                                1'($urandom_range(1)), SDA_RANDOM);
                    run_command(i2cm_pkg::CMD_WRITE, 8'($urandom_range(255)),
                                1'($urandom_range(1)), SDA_RANDOM);
                    repeat ($urandom_range(3, 1))
                    begin
                        if ($urandom_range(1))
                            run_command(i2cm_pkg::CMD_WRITE, 8'($urandom_range(255)),
                                        1'($urandom_range(1)), SDA_RANDOM);
                        else
                            run_command(i2cm_pkg::CMD_READ, 8'($urandom_range(255)),
                                        1'($urandom_range(1)), SDA_RANDOM);
                    end
                    run_command(i2cm_pkg::CMD_STOP, 8'($urandom_range(255)),
                                1'($urandom_range(1)), SDA_RANDOM);
                end
                else
                begin
                    pick = $urandom_range(3);
                    case (pick)
                        0:
                        begin
                            pick = $urandom_range(3);
                            run_command((pick == 0) ? i2cm_pkg::CMD_NONE
                                                    : 3'(i2cm_pkg::CMD_READ + pick),
                                        8'($urandom_range(255)), 1'($urandom_range(1)),
                                        SDA_RANDOM);
                        end
                        1: run_command(i2cm_pkg::CMD_READ, 8'($urandom_range(255)),
                                       1'($urandom_range(1)), SDA_RANDOM);
                        2: run_command(i2cm_pkg::CMD_STOP, 8'($urandom_range(255)),
                                       1'($urandom_range(1)), SDA_RANDOM);
                        default: run_command(i2cm_pkg::CMD_WRITE, 8'($urandom_range(255)),
                                             1'($urandom_range(1)), SDA_RANDOM);
                    endcase
                end
                if (first && p == 2)
                    drain();
                first = 1'b0;
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && bus_word_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
